>>> rtl/core/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, request codes and control types for the text console.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLS   = 80;
  localparam int ROWS   = 25;
  localparam int NCELLS = COLS * ROWS;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int ADDR_W = $clog2(NCELLS);
  localparam int CELL_W = 16;

  typedef enum logic [1:0] {
    REQ_PUT       = 2'd0,
    REQ_BACKSPACE = 2'd1,
    REQ_CLEAR     = 2'd2,
    REQ_READ      = 2'd3
  } req_t;

  localparam logic CFG_DEFAULT_ATTR = 1'b0;
  localparam logic CFG_ERROR_ATTR   = 1'b1;

  localparam logic [7:0] DEFAULT_ATTR_RST = 8'd15;
  localparam logic [7:0] ERROR_ATTR_RST   = 8'd244;

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_BLANK   = 8'h08;
  localparam logic [7:0] CH_E       = 8'h45;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_PLAN,
    ST_EXEC,
    ST_SWEEP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load_item;
    logic plan;
    logic exec;
    logic sweep_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic plan_sweep;
    logic sweep_last;
    logic out_free;
  } sts_t;

endpackage

>>> rtl/core/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer
// 80x25 text console: cell store of char/attribute bytes with a cursor.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ stream (req_type in s_tuser), one result per
// request leaves on the m_ stream (error flag in m_tuser). Registers
// default_attr and error_attr are written through cfg_we/cfg_index/cfg_data.
// A request goes accept, plan, execute, result when no sweep is needed.
// Scrolling is done by moving a base row pointer and blanking one row,
// one cell store write per cycle. Clear screen writes every cell.
// After reset the block zeroes the cell store with s_tready low; config
// writes are taken during that time.
// The result sits in an output register; a stalled receiver holds it there
// and the next request may be accepted meanwhile, but its result waits
// until the register is free.
// ----------------------------------------------------------------------------
module text_console_writer
  import tcw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // char_code[7:0], attr[15:8], col[23:16], row[29:24]
  input  logic [1:0]  s_tuser,   // req_type[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // cursor_col[6:0], cursor_row[11:7],
                                 // read_char[19:12], read_attr[27:20]
  output logic        m_tuser,   // error
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  cmd_t             cmd;
  sts_t             sts;
  logic [COL_W-1:0] cursor_col;
  logic [ROW_W-1:0] cursor_row;
  logic [7:0]       read_char, read_attr;

  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tcw_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_req    (s_tuser),
    .in_char   (s_tdata[7:0]),
    .in_attr   (s_tdata[15:8]),
    .in_col    (s_tdata[23:16]),
    .in_row    (s_tdata[29:24]),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_col   (cursor_col),
    .out_row   (cursor_row),
    .out_char  (read_char),
    .out_attr  (read_attr),
    .out_err   (m_tuser)
  );

  assign m_tdata = {4'd0, read_attr, read_char, cursor_row, cursor_col};

`ifndef ASSERT_OFF
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request accepted while another is in work");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> sts.out_free)
    else $error("result register overwritten before transfer");

  a_single_writer: assert property (@(posedge clk) disable iff (rst)
    !(cmd.exec && cmd.sweep_step))
    else $error("cell write and sweep write in the same cycle");

  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> m_tvalid)
    else $error("loaded result not presented");
`endif

endmodule

>>> rtl/core/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// tcw_ctrl
// Request sequencer: accept, plan, execute, row/screen sweep, result load.
// ----------------------------------------------------------------------------
module tcw_ctrl
  import tcw_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   s_tvalid,
  output logic   s_tready,
  input  sts_t   sts,
  output cmd_t   cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_INIT:  if (sts.sweep_last) state_next = ST_IDLE;
      ST_IDLE:  if (s_tvalid) state_next = ST_PLAN;
      ST_PLAN:  state_next = ST_EXEC;
      ST_EXEC:  state_next = sts.plan_sweep ? ST_SWEEP : ST_DONE;
      ST_SWEEP: if (sts.sweep_last) state_next = ST_DONE;
      ST_DONE:  if (sts.out_free) state_next = ST_IDLE;
      default:  state_next = ST_INIT;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    case (state)
      ST_INIT:  cmd.sweep_step = 1'b1;
      ST_IDLE: begin
        s_tready      = 1'b1;
        cmd.load_item = s_tvalid;
      end
      ST_PLAN:  cmd.plan = 1'b1;
      ST_EXEC:  cmd.exec = 1'b1;
      ST_SWEEP: cmd.sweep_step = 1'b1;
      ST_DONE:  cmd.load_out = sts.out_free;
      default: ;
    endcase
  end

endmodule

>>> rtl/core/tcw_dp.sv
// ----------------------------------------------------------------------------
// tcw_dp
// Cell store, cursor, scroll base row, sweep counter and result register.
// ----------------------------------------------------------------------------
module tcw_dp
  import tcw_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic [1:0]        in_req,
  input  logic [7:0]        in_char,
  input  logic [7:0]        in_attr,
  input  logic [7:0]        in_col,
  input  logic [5:0]        in_row,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [7:0]        cfg_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [COL_W-1:0]  out_col,
  output logic [ROW_W-1:0]  out_row,
  output logic [7:0]        out_char,
  output logic [7:0]        out_attr,
  output logic              out_err
);

  // logical row plus base row, wrapped, gives the physical row
  function automatic logic [ADDR_W-1:0] addr_of(input logic [ROW_W-1:0] lrow,
                                                input logic [COL_W-1:0] c,
                                                input logic [ROW_W-1:0] b);
    logic [ROW_W:0]   sum;
    logic [ROW_W-1:0] prow;
    sum = {1'b0, lrow} + {1'b0, b};
    if (sum >= (ROW_W+1)'(ROWS)) begin
      prow = ROW_W'(sum - (ROW_W+1)'(ROWS));
    end else begin
      prow = sum[ROW_W-1:0];
    end
    return ADDR_W'(prow) * ADDR_W'(COLS) + ADDR_W'(c);
  endfunction

  req_t              item_req;
  logic [7:0]        item_char, item_attr, item_col;
  logic [5:0]        item_row;
  logic [ROW_W-1:0]  cur_row, base;
  logic [COL_W-1:0]  cur_col;
  logic [7:0]        default_attr, error_attr;

  logic              plan_wr, plan_rd, plan_err, plan_sweep;
  logic [ADDR_W-1:0] plan_addr, plan_start, plan_end;
  logic [CELL_W-1:0] plan_data, plan_fill;
  logic [ROW_W-1:0]  plan_base, plan_row;
  logic [COL_W-1:0]  plan_col;

  logic              p_wr, p_rd, p_err, p_sweep;
  logic [ADDR_W-1:0] p_addr, p_start, p_end;
  logic [CELL_W-1:0] p_data, p_fill;
  logic [ROW_W-1:0]  p_base, p_row, wrow, trow;
  logic [COL_W-1:0]  p_col, wcol, tcol;
  logic              off, use_in, last_row, last_col;
  logic [7:0]        eff_attr;
  logic [ADDR_W-1:0] scroll_start;
  logic [ROW_W-1:0]  base_inc;

  logic [ADDR_W-1:0] sweep_addr, sweep_end;
  logic [CELL_W-1:0] sweep_fill;

  logic [CELL_W-1:0] mem [NCELLS];
  logic [CELL_W-1:0] rd_data;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr;
  logic [CELL_W-1:0] mem_wdata;

  // config
  always_ff @(posedge clk) begin
    if (rst) begin
      default_attr <= DEFAULT_ATTR_RST;
      error_attr   <= ERROR_ATTR_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_DEFAULT_ATTR) default_attr <= cfg_data;
      if (cfg_index == CFG_ERROR_ATTR)   error_attr   <= cfg_data;
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_req  <= req_t'(in_req);
      item_char <= in_char;
      item_attr <= in_attr;
      item_col  <= in_col;
      item_row  <= in_row;
    end
  end

  // request decode
  always_comb begin
    off = (!item_col[7] && item_col[COL_W-1:0] >= COL_W'(COLS)) ||
          (!item_row[5] && item_row[ROW_W-1:0] >= ROW_W'(ROWS));
    use_in   = !item_col[7] && !item_row[5] && !off;
    trow     = use_in ? item_row[ROW_W-1:0] : cur_row;
    tcol     = use_in ? item_col[COL_W-1:0] : cur_col;
    eff_attr = (item_attr == 8'd0) ? default_attr : item_attr;
    last_row = (trow == ROW_W'(ROWS - 1));
    last_col = (tcol == COL_W'(COLS - 1));

    scroll_start = ADDR_W'(base) * ADDR_W'(COLS);
    base_inc     = (base == ROW_W'(ROWS - 1)) ? '0 : base + 1'b1;

    p_wr    = 1'b0;
    p_rd    = 1'b0;
    p_err   = 1'b0;
    p_sweep = 1'b0;
    wrow    = trow;
    wcol    = tcol;
    p_data  = {eff_attr, item_char};
    p_row   = cur_row;
    p_col   = cur_col;
    p_start = scroll_start;
    p_end   = scroll_start + ADDR_W'(COLS - 1);
    p_fill  = '0;
    p_base  = base_inc;

    case (item_req)
      REQ_PUT: begin
        if (off) begin
          p_wr   = 1'b1;
          wrow   = ROW_W'(ROWS - 1);
          wcol   = COL_W'(COLS - 1);
          p_data = {error_attr, CH_E};
          p_err  = 1'b1;
        end else if (item_char == CH_NEWLINE) begin
          p_col = '0;
          if (last_row) begin
            p_sweep = 1'b1;
            p_row   = trow;
          end else begin
            p_row = trow + 1'b1;
          end
        end else if (item_char == CH_BLANK) begin
          p_wr   = 1'b1;
          p_data = {eff_attr, CH_SPACE};
          p_row  = trow;
          p_col  = tcol;
        end else begin
          p_wr = 1'b1;
          if (last_col) begin
            p_col = '0;
            if (last_row) begin
              p_sweep = 1'b1;
              p_row   = trow;
            end else begin
              p_row = trow + 1'b1;
            end
          end else begin
            p_row = trow;
            p_col = tcol + 1'b1;
          end
        end
      end
      REQ_BACKSPACE: begin
        p_wr   = 1'b1;
        p_data = {default_attr, CH_SPACE};
        if (cur_col != '0) begin
          wrow = cur_row;
          wcol = cur_col - 1'b1;
        end else if (cur_row != '0) begin
          wrow = cur_row - 1'b1;
          wcol = COL_W'(COLS - 1);
        end else begin
          wrow = '0;
          wcol = '0;
        end
        p_row = wrow;
        p_col = wcol;
      end
      REQ_CLEAR: begin
        p_sweep = 1'b1;
        p_start = '0;
        p_end   = ADDR_W'(NCELLS - 1);
        p_fill  = {default_attr, CH_SPACE};
        p_base  = '0;
        p_row   = '0;
        p_col   = '0;
      end
      REQ_READ: begin
        if (off) begin
          p_err = 1'b1;
        end else begin
          p_rd = 1'b1;
        end
      end
      default: ;
    endcase

    p_addr = addr_of(wrow, wcol, base);
  end

  always_ff @(posedge clk) begin
    if (cmd.plan) begin
      plan_wr    <= p_wr;
      plan_rd    <= p_rd;
      plan_err   <= p_err;
      plan_sweep <= p_sweep;
      plan_addr  <= p_addr;
      plan_data  <= p_data;
      plan_start <= p_start;
      plan_end   <= p_end;
      plan_fill  <= p_fill;
      plan_base  <= p_base;
      plan_row   <= p_row;
      plan_col   <= p_col;
    end
  end

  // cursor, base row, sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row    <= '0;
      cur_col    <= '0;
      base       <= '0;
      sweep_addr <= '0;
      sweep_end  <= ADDR_W'(NCELLS - 1);
      sweep_fill <= '0;
    end else begin
      if (cmd.exec) begin
        cur_row <= plan_row;
        cur_col <= plan_col;
        if (plan_sweep) begin
          base       <= plan_base;
          sweep_addr <= plan_start;
          sweep_end  <= plan_end;
          sweep_fill <= plan_fill;
        end
      end else if (cmd.sweep_step) begin
        sweep_addr <= sweep_addr + 1'b1;
      end
    end
  end

  // cell store
  assign mem_we    = (cmd.exec && plan_wr) || cmd.sweep_step;
  assign mem_addr  = cmd.sweep_step ? sweep_addr : plan_addr;
  assign mem_wdata = cmd.sweep_step ? sweep_fill : plan_data;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && plan_rd) begin
      rd_data <= mem[plan_addr];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_col  <= cur_col;
      out_row  <= cur_row;
      out_char <= plan_rd ? rd_data[7:0]  : 8'd0;
      out_attr <= plan_rd ? rd_data[15:8] : 8'd0;
      out_err  <= plan_err;
    end
  end

  assign sts.plan_sweep = plan_sweep;
  assign sts.sweep_last = (sweep_addr == sweep_end);
  assign sts.out_free   = !out_valid || out_ready;

endmodule

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the text console writer. Requests go in on the
// slave stream and are mirrored by a console model in the bench; each result on
// the master stream is checked against the oldest expectation (model prediction
// or a directed row's own). A directed table runs first, then random phases under
// several register settings, random idle bursts on both streams in all but the last.
// ----------------------------------------------------------------------------
module testbench
  import tcw_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 30000;
  localparam int NDIR = 24;
  localparam int RAND_PER_PHASE = 200;

  // coordinate values that select the cursor cell
  localparam logic [7:0] CUR_C = 8'hFF;
  localparam logic [5:0] CUR_R = 6'h3F;

  typedef struct packed {
    req_t       req;
    logic [7:0] ch;
    logic [7:0] at;
    logic [7:0] col;
    logic [5:0] row;
  } console_req_t;

  typedef struct packed {
    logic [6:0] cur_col;
    logic [4:0] cur_row;
    logic [7:0] rd_char;
    logic [7:0] rd_attr;
    logic       err;
  } console_res_t;

  typedef struct packed {
    logic         has_exp;
    console_res_t exp;
  } typed_exp_t;

  typedef struct packed {
    req_t       req;
    logic [7:0] ch;
    logic [7:0] at;
    logic [7:0] col;
    logic [5:0] row;
    logic       has_exp;
    logic [6:0] e_col;
    logic [4:0] e_row;
    logic [7:0] e_rch;
    logic [7:0] e_rat;
    logic       e_err;
  } dir_row_t;

  localparam dir_row_t DIR_TAB [NDIR] = '{
    '{REQ_READ,      8'h00, 8'h00, 8'd0,  6'd0,  1'b1, 7'd0,  5'd0,  8'h00, 8'h00, 1'b0},
    '{REQ_PUT,       8'h41, 8'h00, CUR_C, CUR_R, 1'b0, 7'd0,  5'd0,  8'h00, 8'h00, 1'b0},
    '{REQ_PUT,       8'h5A, 8'hFF, 8'd127, 6'd0, 1'b1, 7'd1,  5'd0,  8'h00, 8'h00, 1'b1},
    '{REQ_PUT,       8'h5A, 8'h01, 8'd0,  6'd31, 1'b1, 7'd1,  5'd0,  8'h00, 8'h00, 1'b1},
    '{REQ_READ,      8'h00, 8'h00, 8'd79, 6'd24, 1'b1, 7'd1,  5'd0,  CH_E,  8'd244, 1'b0},
    '{REQ_READ,      8'h00, 8'h00, 8'd80, 6'd0,  1'b1, 7'd1,  5'd0,  8'h00, 8'h00, 1'b1},
    '{REQ_READ,      8'h00, 8'h00, 8'd0,  6'd25, 1'b1, 7'd1,  5'd0,  8'h00, 8'h00, 1'b1},
    '{REQ_READ,      8'h00, 8'h00, CUR_C, CUR_R, 1'b0, 7'd0,  5'd0,  8'h00, 8'h00, 1'b0},
    '{REQ_READ,      8'h00, 8'h00, 8'd0,  6'd0,  1'b0, 7'd0,  5'd0,  8'h00, 8'h00, 1'b0},
    '{REQ_PUT,       CH_NEWLINE, 8'h00, CUR_C, CUR_R, 1'b0, 7'd0, 5'd0, 8'h00, 8'h00, 1'b0},
    '{REQ_PUT,       CH_BLANK, 8'h55, 8'd10, 6'd3, 1'b0, 7'd0, 5'd0, 8'h00, 8'h00, 1'b0},
    '{REQ_PUT,       8'hFF, 8'hFF, 8'd79, 6'd24, 1'b0, 7'd0,  5'd0,  8'h00, 8'h00, 1'b0},
    '{REQ_READ,      8'h00, 8'h00, 8'd79, 6'd23, 1'b0, 7'd0,  5'd0,  8'h00, 8'h00, 1'b0},
    '{REQ_PUT,       8'h00, 8'h01, 8'd0,  6'd0,  1'b0, 7'd0,  5'd0,  8'h00, 8'h00, 1'b0},
    '{REQ_BACKSPACE, 8'h00, 8'h00, CUR_C, CUR_R, 1'b0, 7'd0,  5'd0,  8'h00, 8'h00, 1'b0},
    '{REQ_BACKSPACE, 8'hFF, 8'hFF, 8'd5,  6'd5,  1'b1, 7'd0,  5'd0,  8'h00, 8'h00, 1'b0},
    '{REQ_PUT,       CH_NEWLINE, 8'h00, 8'd5, 6'd24, 1'b0, 7'd0, 5'd0, 8'h00, 8'h00, 1'b0},
    '{REQ_PUT,       CH_BLANK, 8'h00, 8'd79, 6'd24, 1'b0, 7'd0, 5'd0, 8'h00, 8'h00, 1'b0},
    '{REQ_PUT,       8'h78, 8'h80, 8'h80, 6'd0,  1'b0, 7'd0,  5'd0,  8'h00, 8'h00, 1'b0},
    '{REQ_PUT,       8'h71, 8'h7F, 8'd3,  6'h20, 1'b0, 7'd0,  5'd0,  8'h00, 8'h00, 1'b0},
    '{REQ_PUT,       8'h71, 8'h00, 8'd127, 6'h20, 1'b0, 7'd0, 5'd0,  8'h00, 8'h00, 1'b0},
    '{REQ_CLEAR,     8'h00, 8'h00, CUR_C, CUR_R, 1'b1, 7'd0,  5'd0,  8'h00, 8'h00, 1'b0},
    '{REQ_READ,      8'h00, 8'h00, 8'd40, 6'd12, 1'b1, 7'd0,  5'd0,  CH_SPACE, 8'd15, 1'b0},
    '{REQ_READ,      8'h00, 8'h00, CUR_C, 6'd0,  1'b0, 7'd0,  5'd0,  8'h00, 8'h00, 1'b0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // char_code[7:0], attr[15:8], col[23:16], row[29:24]
  logic [1:0]  s_tuser = '0;   // req_type[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // cursor_col[6:0], cursor_row[11:7],
                               // read_char[19:12], read_attr[27:20]
  logic        m_tuser;        // error
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_DEFAULT_ATTR;
  logic [7:0]  cfg_data = '0;

  // console model state
  logic [15:0] scr [NCELLS];
  int          cur_cell;
  logic [7:0]  dflt_attr;
  logic [7:0]  err_attr;

  console_res_t pending_res [$];
  typed_exp_t   typed_q [$];
  int           sent_cnt = 0;
  int           done_cnt = 0;
  int           fail_cnt = 0;
  int           quiet_cycles = 0;
  int           stall_left = 0;
  logic         idle_en = 1'b1;

  text_console_writer DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  task automatic put_cell(input int idx, input logic [7:0] ch, input logic [7:0] at);
    if (idx < NCELLS) scr[idx] = {at, ch};
  endtask

  task automatic settle_cursor(input int nxt);
    int i;
    if (nxt >= NCELLS) begin
      for (i = 0; i + COLS < NCELLS; i++) scr[i] = scr[i + COLS];
      for (i = NCELLS - COLS; i < NCELLS; i++) scr[i] = '0;
      nxt -= COLS;
    end
    cur_cell = (nxt < NCELLS) ? nxt : 0;
  endtask

  task automatic console_step(input console_req_t it, output console_res_t res);
    int         c;
    int         r;
    int         tgt;
    int         i;
    logic       off;
    logic [7:0] at;
    c   = $signed(it.col);
    r   = $signed(it.row);
    off = (c >= COLS) || (r >= ROWS);
    tgt = cur_cell;
    at  = (it.at == 8'h00) ? dflt_attr : it.at;
    res = '0;
    if (c >= 0 && r >= 0 && !off) tgt = r * COLS + c;
    case (it.req)
      REQ_PUT: begin
        if (off) begin
          put_cell(NCELLS - 1, CH_E, err_attr);
          res.err = 1'b1;
        end else if (it.ch == CH_NEWLINE) begin
          settle_cursor((tgt / COLS + 1) * COLS);
        end else if (it.ch == CH_BLANK) begin
          put_cell(tgt, CH_SPACE, at);
          settle_cursor(tgt);
        end else begin
          put_cell(tgt, it.ch, at);
          settle_cursor(tgt + 1);
        end
      end
      REQ_BACKSPACE: begin
        if (cur_cell > 0) cur_cell = cur_cell - 1;
        put_cell(cur_cell, CH_SPACE, dflt_attr);
      end
      REQ_CLEAR: begin
        for (i = 0; i < NCELLS; i++) put_cell(i, CH_SPACE, dflt_attr);
        cur_cell = 0;
      end
      default: begin
        if (off) begin
          res.err = 1'b1;
        end else begin
          res.rd_char = scr[tgt][7:0];
          res.rd_attr = scr[tgt][15:8];
        end
      end
    endcase
    res.cur_col = 7'(cur_cell % COLS);
    res.cur_row = 5'(cur_cell / COLS);
  endtask

  task automatic field_check(input string name, input int e, input int a);
    if (e != a) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, e, a);
      fail_cnt++;
    end
  endtask

  // prediction on input transfers, comparison on output transfers
  always @(posedge clk) begin
    console_req_t it;
    console_res_t pred;
    console_res_t got;
    typed_exp_t   tag;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        it.req = req_t'(s_tuser);
        it.ch  = s_tdata[7:0];
        it.at  = s_tdata[15:8];
        it.col = s_tdata[23:16];
        it.row = s_tdata[29:24];
        console_step(it, pred);
        tag = typed_q.pop_front();
        pending_res.push_back(tag.has_exp ? tag.exp : pred);
      end
      if (m_tvalid && m_tready) begin
        done_cnt++;
        got = '{m_tdata[6:0], m_tdata[11:7], m_tdata[19:12], m_tdata[27:20], m_tuser};
        if (pending_res.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual %h", $time, got);
          fail_cnt++;
        end else begin
          pred = pending_res.pop_front();
          field_check("cursor_col", pred.cur_col, got.cur_col);
          field_check("cursor_row", pred.cur_row, got.cur_row);
          field_check("read_char", pred.rd_char, got.rd_char);
          field_check("read_attr", pred.rd_attr, got.rd_attr);
          field_check("error", pred.err, got.err);
        end
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 17) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_req(input console_req_t it, input typed_exp_t tag);
    typed_q.push_back(tag);
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, it.row, it.col, it.at, it.ch};
    s_tuser  <= it.req;
    do @(posedge clk); while (s_tready !== 1'b1);
    sent_cnt++;
  endtask

  task automatic sender_gap();
    if (idle_en && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (done_cnt != sent_cnt) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_regs(input logic [7:0] dflt, input logic [7:0] errv);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DEFAULT_ATTR;
    cfg_data  <= dflt;
    @(posedge clk);
    cfg_index <= CFG_ERROR_ATTR;
    cfg_data  <= errv;
    @(posedge clk);
    cfg_we    <= 1'b0;
    dflt_attr = dflt;
    err_attr  = errv;
  endtask

  function automatic console_req_t rand_req();
    console_req_t it;
    int           p;
    p = $urandom_range(0, 99);
    it.req = (p < 68) ? REQ_PUT : (p < 78) ? REQ_BACKSPACE : (p < 80) ? REQ_CLEAR : REQ_READ;
    p = $urandom_range(0, 99);
    it.ch = (p < 10) ? CH_NEWLINE : (p < 20) ? CH_BLANK : 8'($urandom_range(0, 255));
    it.at = ($urandom_range(0, 6) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
    p = $urandom_range(0, 99);
    if (p < 50) begin
      // cursor cell: at least one coordinate negative; the other on screen or also negative
      it.col = ($urandom_range(0, 9) < 3) ? 8'($urandom_range(0, COLS - 1))
                                          : 8'($urandom_range(128, 255));
      it.row = (it.col[7] && $urandom_range(0, 1)) ? 6'($urandom_range(0, ROWS - 1))
                                                   : 6'($urandom_range(32, 63));
    end else if (p < 85) begin
      it.col = ($urandom_range(0, 4) == 0) ? 8'(COLS - 1) : 8'($urandom_range(0, COLS - 1));
      it.row = ($urandom_range(0, 9) < 3) ? 6'(ROWS - 1) : 6'($urandom_range(0, ROWS - 1));
    end else begin
      it.col = 8'($urandom_range(0, 255));
      it.row = 6'($urandom_range(0, 63));
    end
    return it;
  endfunction

  task automatic run_random(input int n);
    repeat (n) begin
      sender_gap();
      send_req(rand_req(), '0);
    end
  endtask

  initial begin
    console_req_t it;
    typed_exp_t   tag;
    for (int i = 0; i < NCELLS; i++) scr[i] = '0;
    cur_cell  = 0;
    dflt_attr = DEFAULT_ATTR_RST;
    err_attr  = ERROR_ATTR_RST;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NDIR; i++) begin
      it  = '{DIR_TAB[i].req, DIR_TAB[i].ch, DIR_TAB[i].at, DIR_TAB[i].col, DIR_TAB[i].row};
      tag = '{DIR_TAB[i].has_exp, '{DIR_TAB[i].e_col, DIR_TAB[i].e_row,
                                    DIR_TAB[i].e_rch, DIR_TAB[i].e_rat, DIR_TAB[i].e_err}};
      sender_gap();
      send_req(it, tag);
    end

    drain();
    write_regs(8'h00, 8'h00);
    run_random(RAND_PER_PHASE);
    drain();
    write_regs(8'hFF, 8'hFF);
    run_random(RAND_PER_PHASE);
    drain();
    write_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    run_random(RAND_PER_PHASE);
    drain();
    write_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    idle_en = 1'b0;
    run_random(RAND_PER_PHASE);
    drain();

    if (fail_cnt == 0 && pending_res.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> text_console_writer.f
rtl/core/tcw_pkg.sv
rtl/core/tcw_ctrl.sv
rtl/core/tcw_dp.sv
rtl/core/text_console_writer.sv
bench/testbench.sv
